>>> rtl/lcabl_pkg.sv
// Package with the shared types and codes of the lowest-common-ancestor engine.
`timescale 1ns / 1ps

package lcabl_pkg;

    // Width of a node field and of a stored depth.
    localparam int VAL_W = 16;

    // Item kinds carried on the mode field.
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRAP,
        S_LOAD,
        S_ADD_DRD,
        S_ADD_DWR,
        S_ADD_RD,
        S_ADD_WB,
        S_ADD_FIN,
        S_Q_RDU,
        S_Q_RDV,
        S_Q_DIFF,
        S_Q_UP,
        S_Q_UPW,
        S_Q_EQ,
        S_Q_RFU,
        S_Q_RFV,
        S_Q_CMP,
        S_Q_RANS,
        S_Q_ANS,
        S_Q_OUT
    } t_state;

endpackage

>>> rtl/lca_binary_lifting.sv
// Binary-lifting lowest-common-ancestor engine: top level with depth and ancestor memories.
// An add writes its table entries one level after another; a query loads its result into the
// output register, later while the previous result is stalled there. Indices are wrapped modulo
// NODES by reciprocal multiplication when NODES < 65536.
// One item at a time: the next is taken only after the last finishes, since every lifting step
// waits for a dependent read. A result waits in the output register meanwhile.
// Reset clears only the control state; both memories are undefined until written.
`timescale 1ns / 1ps

module lca_binary_lifting #(
    parameter int NODES  = 65536,
    parameter int LEVELS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [15:0] i_node_a,
    input  logic [15:0] i_node_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_ancestor
);
    import lcabl_pkg::*;

    localparam int DEP_N     = (NODES < 65536) ? NODES : 65536;
    localparam int VW        = $clog2(DEP_N);
    localparam int LW        = $clog2(LEVELS);
    localparam int TAB_N     = DEP_N * LEVELS;
    localparam int TAW       = $clog2(TAB_N);
    localparam bit WRAP_ON   = (NODES < 65536);
    localparam int MOD_STEPS = WRAP_ON ? 2 : 0;
    localparam int WCW       = 1;
    // Reciprocal of NODES scaled by 2^32; it gives exact quotients for any 16-bit index.
    localparam logic [31:0] RECIP = WRAP_ON ?
        32'((64'd1 << 32) / 64'(NODES) + 64'd1) : 32'd0;
    localparam logic [VAL_W-1:0] NODE_MOD = VAL_W'(NODES);

    // An ancestor entry keeps the node as written and its wrapped index.
    typedef struct packed {
        logic [VAL_W-1:0] raw;
        logic [VW-1:0]    node;
    } t_entry;

    function automatic logic [TAW-1:0] tab_addr(input logic [VW-1:0] node,
                                                 input logic [LW-1:0] lvl);
        return TAW'(node) * TAW'(LEVELS) + TAW'(lvl);
    endfunction

    t_state r_state, n_state;

    logic              r_mode;
    logic [VAL_W-1:0]  r_wa, r_wb, r_braw;
    logic [VAL_W-1:0]  r_qa, r_qb;
    logic [WCW-1:0]    r_wcnt;
    logic [VW-1:0]     r_u, r_v;
    logic [LW-1:0]     r_lvl;
    logic [LEVELS-1:0] r_diff;
    logic [VAL_W-1:0]  r_du;
    t_entry            r_ent, r_fu;
    logic              r_fwd;
    logic [VAL_W-1:0]  r_res;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_ancestor;

    t_entry            r_tab [TAB_N];
    logic [VAL_W-1:0]  r_dep [DEP_N];
    t_entry            r_tab_q;
    logic [VAL_W-1:0]  r_dep_q;

    // Memory control and handshake, decoded from the state.
    logic              tab_rd_en, tab_wr_en, dep_rd_en, dep_wr_en;
    logic [VW-1:0]     tab_rd_node, dep_rd_node;
    logic [LW-1:0]     tab_rd_lvl;
    logic              out_load;
    logic              accept;

    logic [VAL_W-1:0]  w_qa, w_qb;
    logic [VAL_W-1:0]  w_wa, w_wb;
    t_entry            w_ent;
    logic [VAL_W-1:0]  w_dep_wdata;

    assign accept = i_valid && !o_stall;

    // Wrap modulo NODES in two steps: quotients by reciprocal multiplication, then remainders.
    assign w_qa = VAL_W'((48'(r_wa) * 48'(RECIP)) >> 32);
    assign w_qb = VAL_W'((48'(r_wb) * 48'(RECIP)) >> 32);
    assign w_wa = r_wa - r_qa * NODE_MOD;
    assign w_wb = r_wb - r_qb * NODE_MOD;

    // A read of the entry written in the same cycle takes the written value.
    assign w_ent       = r_fwd ? r_ent : r_tab_q;
    assign w_dep_wdata = (r_u == r_v) ? '0 : r_dep_q + 16'd1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (MOD_STEPS > 0) ? S_WRAP : S_LOAD;
                end
            end
            S_WRAP: begin
                if (r_wcnt == '0) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:    n_state = (r_mode == MODE_QUERY) ? S_Q_RDU : S_ADD_DRD;
            S_ADD_DRD: n_state = S_ADD_DWR;
            S_ADD_DWR: n_state = S_ADD_RD;
            S_ADD_RD:  n_state = S_ADD_WB;
            S_ADD_WB:  n_state = (r_lvl == LW'(LEVELS - 2)) ? S_ADD_FIN : S_ADD_RD;
            S_ADD_FIN: n_state = S_IDLE;
            S_Q_RDU:   n_state = S_Q_RDV;
            S_Q_RDV:   n_state = S_Q_DIFF;
            S_Q_DIFF:  n_state = S_Q_UP;
            S_Q_UP: begin
                if (r_diff == '0) begin
                    n_state = S_Q_EQ;
                end else if (r_diff[0]) begin
                    n_state = S_Q_UPW;
                end
            end
            S_Q_UPW:   n_state = S_Q_UP;
            S_Q_EQ:    n_state = (r_u == r_v) ? S_Q_OUT : S_Q_RFU;
            S_Q_RFU:   n_state = S_Q_RFV;
            S_Q_RFV:   n_state = S_Q_CMP;
            S_Q_CMP:   n_state = (r_lvl == '0) ? S_Q_RANS : S_Q_RFU;
            S_Q_RANS:  n_state = S_Q_ANS;
            S_Q_ANS:   n_state = S_Q_OUT;
            S_Q_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        tab_rd_en   = 1'b0;
        tab_rd_node = r_u;
        tab_rd_lvl  = r_lvl;
        tab_wr_en   = 1'b0;
        dep_rd_en   = 1'b0;
        dep_rd_node = r_u;
        dep_wr_en   = 1'b0;
        out_load    = 1'b0;
        o_stall     = 1'b1;
        case (r_state)
            S_IDLE:    o_stall = 1'b0;
            S_ADD_DRD: begin
                dep_rd_en   = 1'b1;
                dep_rd_node = r_v;
            end
            S_ADD_DWR: dep_wr_en = 1'b1;
            S_ADD_RD: begin
                tab_wr_en   = 1'b1;
                tab_rd_en   = 1'b1;
                tab_rd_node = r_ent.node;
            end
            S_ADD_FIN: tab_wr_en = 1'b1;
            S_Q_RDU:   dep_rd_en = 1'b1;
            S_Q_RDV: begin
                dep_rd_en   = 1'b1;
                dep_rd_node = r_v;
            end
            S_Q_UP:    tab_rd_en = r_diff[0];
            S_Q_RFU:   tab_rd_en = 1'b1;
            S_Q_RFV: begin
                tab_rd_en   = 1'b1;
                tab_rd_node = r_v;
            end
            S_Q_RANS: begin
                tab_rd_en  = 1'b1;
                tab_rd_lvl = '0;
            end
            S_Q_OUT:   out_load = !r_out_valid || !i_stall;
            default: begin
                tab_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tab_wr_en) begin
            r_tab[tab_addr(r_u, r_lvl)] <= r_ent;
        end
        if (tab_rd_en) begin
            r_tab_q <= r_tab[tab_addr(tab_rd_node, tab_rd_lvl)];
        end
        if (dep_wr_en) begin
            r_dep[r_u] <= w_dep_wdata;
        end
        if (dep_rd_en) begin
            r_dep_q <= r_dep[dep_rd_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_mode <= i_mode;
                    r_wa   <= i_node_a;
                    r_wb   <= i_node_b;
                    r_braw <= i_node_b;
                    r_wcnt <= WCW'(MOD_STEPS - 1);
                end
            end
            S_WRAP: begin
                if (r_wcnt != '0) begin
                    r_qa <= w_qa;
                    r_qb <= w_qb;
                end else begin
                    r_wa <= w_wa;
                    r_wb <= w_wb;
                end
                r_wcnt <= r_wcnt - 1'b1;
            end
            S_LOAD: begin
                r_u <= VW'(r_wa);
                r_v <= VW'(r_wb);
            end
            S_ADD_DWR: begin
                r_ent.raw  <= r_braw;
                r_ent.node <= r_v;
                r_lvl      <= '0;
            end
            S_ADD_RD:  r_fwd <= (r_ent.node == r_u);
            S_ADD_WB: begin
                r_ent <= w_ent;
                r_lvl <= r_lvl + 1'b1;
            end
            S_Q_RDV:   r_du <= r_dep_q;
            S_Q_DIFF: begin
                r_lvl <= '0;
                if (r_du < r_dep_q) begin
                    r_u    <= r_v;
                    r_v    <= r_u;
                    r_diff <= LEVELS'(r_dep_q - r_du);
                end else begin
                    r_diff <= LEVELS'(r_du - r_dep_q);
                end
            end
            S_Q_UP: begin
                if (!r_diff[0]) begin
                    r_diff <= r_diff >> 1;
                    r_lvl  <= r_lvl + 1'b1;
                end
            end
            S_Q_UPW: begin
                r_u    <= r_tab_q.node;
                r_diff <= r_diff >> 1;
                r_lvl  <= r_lvl + 1'b1;
            end
            S_Q_EQ: begin
                r_res <= VAL_W'(r_u);
                r_lvl <= LW'(LEVELS - 1);
            end
            S_Q_RFV:   r_fu <= r_tab_q;
            S_Q_CMP: begin
                // Both nodes move up only while their ancestors at this level differ.
                if (r_fu.raw != r_tab_q.raw) begin
                    r_u <= r_fu.node;
                    r_v <= r_tab_q.node;
                end
                r_lvl <= r_lvl - 1'b1;
            end
            S_Q_ANS:   r_res <= r_tab_q.raw;
            default: begin
                r_fwd <= r_fwd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ancestor <= r_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ancestor = r_ancestor;

endmodule

>>> rtl/lcabl_checker.sv
// Port-level checker for the lowest-common-ancestor engine, bound to its top level.
`timescale 1ns / 1ps

module lcabl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_mode,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_ancestor
);
    import lcabl_pkg::*;

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_ancestor)))
        else $error("result changed while stalled");

    // Every accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block free right after taking an item");

    // A new result comes only out of a query that was still in progress.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while the block was idle");

    // Delivering a result frees the block for the next item at once.
    a_free_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("block still busy after loading a result");

    // An add item taken while no result is held never produces a result on the next cycle.
    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_mode == MODE_ADD && !o_valid) |=> !o_valid)
        else $error("add item produced a result");

endmodule

bind lca_binary_lifting lcabl_checker u_lcabl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_mode     (i_mode),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_ancestor (o_ancestor)
);
